// ===== src/assert_macros.svh =====
// assertion macros for the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("check failed");
`define CHK_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition");
`else
`define CHK_IMPL(label, clk, rst, prop)
`define CHK_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== src/bra_pkg.sv =====
// shared types, constants and codes for the banker's allocator
package bra_pkg;
   localparam int NUM_PROC  = 8;
   localparam int NUM_RES   = 4;
   localparam int UNIT_BITS = 8;
   localparam int PROC_BITS = (NUM_PROC > 1) ? $clog2(NUM_PROC) : 1;
   localparam int CNT_BITS  = $clog2(NUM_PROC + 1);
   localparam int WORK_BITS = UNIT_BITS + $clog2(NUM_PROC + 1);

   localparam logic [2:0] OP_LOAD_ALLOC = 3'd0;
   localparam logic [2:0] OP_LOAD_MAX   = 3'd1;
   localparam logic [2:0] OP_LOAD_AVAIL = 3'd2;
   localparam logic [2:0] OP_REQUEST    = 3'd3;
   localparam logic [2:0] OP_RELEASE    = 3'd4;
   localparam logic [2:0] OP_QUERY      = 3'd5;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_CLAIM    = 3'd1;
   localparam logic [2:0] ST_NOTAVAIL = 3'd2;
   localparam logic [2:0] ST_UNSAFE   = 3'd3;
   localparam logic [2:0] ST_OVERREL  = 3'd4;
   localparam logic [2:0] ST_BADLOAD  = 3'd5;

   typedef logic [UNIT_BITS-1:0] unit_type;
   typedef unit_type [NUM_RES-1:0] row_type;
   typedef logic [WORK_BITS-1:0] work_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic [2:0] process;
      logic [7:0] amount_0;
      logic [7:0] amount_1;
      logic [7:0] amount_2;
      logic [7:0] amount_3;
   } req_word_type;

   typedef struct packed {
      logic [2:0] status;
      logic [2:0] seq_process;
      logic       last;
   } rsp_word_type;

   typedef enum logic [3:0] {
      S_IDLE, S_EXEC, S_SAFE_INIT, S_SCAN, S_PASS_END, S_SAFE_DONE,
      S_EMIT_ONE, S_EMIT_SEQ
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic latch;
      logic exec;
      logic safe_init;
      logic scan_step;
      logic pass_clear;
      logic rollback;
      logic emit_one;
      logic emit_seq;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_safety;
      logic is_query;
      logic scan_last;
      logic progress;
      logic all_done;
      logic seq_last;
   } sts_type;
endpackage

// ===== src/bra_datapath.sv =====
// datapath: state tables, checks, safety scan unit and result formatting
`include "assert_macros.svh"
module bra_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  bra_pkg::req_word_type req_word,
   input  bra_pkg::cmd_type      cmd,
   output bra_pkg::sts_type      sts,
   output logic                  rsp_strobe,
   output bra_pkg::rsp_word_type rsp_word
);
   import bra_pkg::*;

   row_type   avail_ff, avail_in;
   row_type   held_ff  [NUM_PROC];
   row_type   need_ff  [NUM_PROC];
   req_word_type op_ff;
   row_type   amt;
   logic [2:0] status_ff, status_in;
   logic      grant_ff, grant_in;
   work_type  work_ff [NUM_RES];
   logic [NUM_PROC-1:0] done_ff;
   logic [PROC_BITS-1:0] scan_ff;
   logic [PROC_BITS-1:0] order_ff [NUM_PROC];
   logic [CNT_BITS-1:0] count_ff;
   logic [PROC_BITS-1:0] rd_ff;
   logic      progress_ff;
   logic      pok;
   logic [PROC_BITS-1:0] pidx;
   logic      over_claim, over_avail, over_held, below_held, fits;
   logic      rsp_strobe_ff;
   rsp_word_type rsp_ff;

   assign amt[0] = op_ff.amount_0[UNIT_BITS-1:0];
   if (NUM_RES > 1) begin : g_r1
      assign amt[1 % NUM_RES] = op_ff.amount_1[UNIT_BITS-1:0];
   end
   if (NUM_RES > 2) begin : g_r2
      assign amt[2 % NUM_RES] = op_ff.amount_2[UNIT_BITS-1:0];
   end
   if (NUM_RES > 3) begin : g_r3
      assign amt[3 % NUM_RES] = op_ff.amount_3[UNIT_BITS-1:0];
   end

   assign pok  = ({1'b0, op_ff.process} < (CNT_BITS+1)'(NUM_PROC));
   assign pidx = PROC_BITS'(op_ff.process);

   always_comb begin
      over_claim = 1'b0;
      over_avail = 1'b0;
      over_held  = 1'b0;
      below_held = 1'b0;
      fits       = 1'b1;
      for (int r = 0; r < NUM_RES; r++) begin
         if (amt[r] > need_ff[pidx][r]) over_claim = 1'b1;
         if (amt[r] > avail_ff[r]) over_avail = 1'b1;
         if (amt[r] > held_ff[pidx][r]) over_held = 1'b1;
         if (amt[r] < held_ff[pidx][r]) below_held = 1'b1;
         if (WORK_BITS'(need_ff[scan_ff][r]) > work_ff[r]) fits = 1'b0;
      end
   end

   // decision on the latched word
   always_comb begin
      status_in = ST_OK;
      grant_in  = 1'b0;
      unique case (op_ff.req_type)
         OP_LOAD_ALLOC, OP_LOAD_MAX: begin
            if (!pok || (op_ff.req_type == OP_LOAD_MAX && below_held)) status_in = ST_BADLOAD;
         end
         OP_REQUEST: begin
            priority if (!pok || over_claim) status_in = ST_CLAIM;
            else if (over_avail) status_in = ST_NOTAVAIL;
            else grant_in = 1'b1;
         end
         OP_RELEASE: begin
            if (!pok || over_held) status_in = ST_OVERREL;
         end
         default: status_in = ST_OK;
      endcase
   end

   always_comb begin
      avail_in = avail_ff;
      for (int r = 0; r < NUM_RES; r++) begin
         logic [UNIT_BITS:0] s;
         s = {1'b0, avail_ff[r]} + {1'b0, amt[r]};
         if (cmd.exec && op_ff.req_type == OP_LOAD_AVAIL) avail_in[r] = amt[r];
         else if (cmd.exec && grant_in) avail_in[r] = avail_ff[r] - amt[r];
         else if (cmd.exec && op_ff.req_type == OP_RELEASE && status_in == ST_OK)
            avail_in[r] = s[UNIT_BITS] ? {UNIT_BITS{1'b1}} : s[UNIT_BITS-1:0];
         else if (cmd.rollback) avail_in[r] = avail_ff[r] + amt[r];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avail_ff <= '0;
         for (int p = 0; p < NUM_PROC; p++) begin
            held_ff[p] <= '0;
            need_ff[p] <= '0;
         end
         done_ff       <= '0;
         count_ff      <= '0;
         scan_ff       <= '0;
         rd_ff         <= '0;
         progress_ff   <= 1'b0;
         grant_ff      <= 1'b0;
         status_ff     <= ST_OK;
         rsp_strobe_ff <= 1'b0;
      end else begin
         avail_ff      <= avail_in;
         rsp_strobe_ff <= cmd.emit_one || cmd.emit_seq;
         if (cmd.exec) begin
            status_ff <= status_in;
            grant_ff  <= grant_in;
            for (int r = 0; r < NUM_RES; r++) begin
               unique case (op_ff.req_type)
                  OP_LOAD_ALLOC: if (status_in == ST_OK) begin
                     held_ff[pidx][r] <= amt[r];
                     need_ff[pidx][r] <= '0;
                  end
                  OP_LOAD_MAX: if (status_in == ST_OK)
                     need_ff[pidx][r] <= amt[r] - held_ff[pidx][r];
                  OP_REQUEST: if (grant_in) begin
                     held_ff[pidx][r] <= held_ff[pidx][r] + amt[r];
                     need_ff[pidx][r] <= need_ff[pidx][r] - amt[r];
                  end
                  OP_RELEASE: if (status_in == ST_OK) begin
                     held_ff[pidx][r] <= held_ff[pidx][r] - amt[r];
                     need_ff[pidx][r] <= need_ff[pidx][r] + amt[r];
                  end
                  default: ;
               endcase
            end
         end
         if (cmd.rollback) begin
            status_ff <= ST_UNSAFE;
            for (int r = 0; r < NUM_RES; r++) begin
               held_ff[pidx][r] <= held_ff[pidx][r] - amt[r];
               need_ff[pidx][r] <= need_ff[pidx][r] + amt[r];
            end
         end
         if (cmd.safe_init) begin
            done_ff     <= '0;
            count_ff    <= '0;
            scan_ff     <= '0;
            rd_ff       <= '0;
            progress_ff <= 1'b0;
            for (int r = 0; r < NUM_RES; r++) work_ff[r] <= WORK_BITS'(avail_ff[r]);
         end
         if (cmd.scan_step) begin
            if (!done_ff[scan_ff] && fits) begin
               done_ff[scan_ff]   <= 1'b1;
               order_ff[count_ff[PROC_BITS-1:0]] <= scan_ff;
               count_ff           <= count_ff + 1'b1;
               progress_ff        <= 1'b1;
               for (int r = 0; r < NUM_RES; r++)
                  work_ff[r] <= work_ff[r] + WORK_BITS'(held_ff[scan_ff][r]);
            end
            scan_ff <= (scan_ff == PROC_BITS'(NUM_PROC - 1)) ? '0 : scan_ff + 1'b1;
         end
         if (cmd.pass_clear) progress_ff <= 1'b0;
         if (cmd.emit_seq) rd_ff <= rd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) op_ff <= req_word;
      if (cmd.emit_one) begin
         rsp_ff.status      <= (op_ff.req_type == OP_QUERY) ? ST_UNSAFE : status_ff;
         rsp_ff.seq_process <= '0;
         rsp_ff.last        <= 1'b1;
      end else if (cmd.emit_seq) begin
         rsp_ff.status      <= ST_OK;
         rsp_ff.seq_process <= 3'(order_ff[rd_ff]);
         rsp_ff.last        <= (rd_ff == PROC_BITS'(NUM_PROC - 1));
      end
   end

   assign sts.need_safety = grant_ff;
   assign sts.is_query    = (op_ff.req_type == OP_QUERY);
   assign sts.scan_last   = (scan_ff == PROC_BITS'(NUM_PROC - 1));
   assign sts.progress    = progress_ff;
   assign sts.all_done    = (count_ff == CNT_BITS'(NUM_PROC));
   assign sts.seq_last    = (rd_ff == PROC_BITS'(NUM_PROC - 1));
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_word        = rsp_ff;

   `CHK_NEVER(a_count_range, clock, reset, count_ff > CNT_BITS'(NUM_PROC))
   `CHK_IMPL(a_count_done, clock, reset, sts.all_done |-> &done_ff)
   `CHK_NEVER(a_emit_both, clock, reset, cmd.emit_one && cmd.emit_seq)
endmodule

// ===== src/bra_ctrl.sv =====
// controller state machine for the banker's allocator
`include "assert_macros.svh"
module bra_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bra_pkg::sts_type sts,
   output bra_pkg::cmd_type cmd
);
   import bra_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:      if (start) state_in = S_EXEC;
         S_EXEC:      state_in = sts.is_query ? S_SAFE_INIT : S_PASS_END;
         S_PASS_END:  state_in = sts.need_safety ? S_SAFE_INIT : S_EMIT_ONE;
         S_SAFE_INIT: state_in = S_SCAN;
         S_SCAN:      if (sts.scan_last) state_in = S_SAFE_DONE;
         S_SAFE_DONE: begin
            priority if (sts.all_done) state_in = sts.is_query ? S_EMIT_SEQ : S_EMIT_ONE;
            else if (sts.progress) state_in = S_SCAN;
            else state_in = S_EMIT_ONE;
         end
         S_EMIT_ONE:  state_in = S_IDLE;
         S_EMIT_SEQ:  if (sts.seq_last) state_in = S_IDLE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         S_IDLE:      cmd.latch = start;
         S_EXEC:      cmd.exec = !sts.is_query;
         S_SAFE_INIT: cmd.safe_init = 1'b1;
         S_SCAN:      cmd.scan_step = 1'b1;
         S_SAFE_DONE: begin
            cmd.pass_clear = 1'b1;
            // unsafe grant is undone before the status goes out
            cmd.rollback = !sts.all_done && !sts.progress && !sts.is_query;
         end
         S_EMIT_ONE:  cmd.emit_one = 1'b1;
         S_EMIT_SEQ:  cmd.emit_seq = 1'b1;
         default:     cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff != S_IDLE);

   `CHK_IMPL(a_start_go, clock, reset, (start && !busy) |=> state_ff == S_EXEC)
   `CHK_IMPL(a_emit_idle, clock, reset, cmd.emit_one |=> state_ff == S_IDLE)
   `CHK_NEVER(a_roll_query, clock, reset, cmd.rollback && sts.is_query)
endmodule

// ===== src/bankers_resource_allocator.sv =====
// top level of the banker's deadlock-avoidance unit
// Usage: drive req_word and raise start while busy is low; the word is taken at that
// edge and busy stays high until the last response word has gone out.
// Each response word shows on rsp_word for one cycle with rsp_strobe high; the
// receiver cannot stall it. rsp_word.last marks the final word of an item.
// Loads, releases and refused requests answer without a scan. A granted request
// and a query run the safety scan: each pass steps through the process rows and
// then a pass-end step, at most NUM_PROC passes, after which the request answers or
// the query sends its words.
// A safe query sends NUM_PROC words on back-to-back cycles; an unsafe one sends one.
// The scan is a single shared compare/add unit stepping through the rows.
// Synchronous reset clears all held, need and available tables to zero; no item is
// taken until reset is low.
module bankers_resource_allocator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  bra_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output bra_pkg::rsp_word_type rsp_word
);
   import bra_pkg::*;

   cmd_type cmd;
   sts_type sts;

   bra_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .sts(sts), .cmd(cmd)
   );

   bra_datapath u_dp (
      .clock(clock), .reset(reset), .req_word(req_word), .cmd(cmd), .sts(sts),
      .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
   );
endmodule

// ===== verif/bankers_resource_allocator_test.sv =====
// testbench for the banker's allocator: directed and random words checked against a predictor
module bankers_resource_allocator_test;
   import bra_pkg::*;

   // operation codes the block ignores
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_word = '0;
   logic         rsp_strobe;
   rsp_word_type rsp_word;

   bankers_resource_allocator u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_strobe(rsp_strobe), .rsp_word(rsp_word)
   );

   always #5 clock = ~clock;

   // predicted allocator state
   int unsigned  pool[NUM_RES];
   int unsigned  held[NUM_PROC][NUM_RES];
   int unsigned  need[NUM_PROC][NUM_RES];
   int unsigned  safe_order[NUM_PROC];
   rsp_word_type pending_rsp[$];
   int           errors = 0;
   bit           allow_gaps = 1'b1;

   function automatic bit state_is_safe();
      int unsigned work[NUM_RES];
      bit          done[NUM_PROC];
      int          count;
      bit          progress;
      bit          fits;
      count = 0;
      for (int r = 0; r < NUM_RES; r++) work[r] = pool[r];
      for (int p = 0; p < NUM_PROC; p++) done[p] = 1'b0;
      while (count < NUM_PROC) begin
         progress = 1'b0;
         for (int p = 0; p < NUM_PROC; p++) begin
            if (!done[p]) begin
               fits = 1'b1;
               for (int r = 0; r < NUM_RES; r++)
                  if (need[p][r] > work[r]) fits = 1'b0;
               if (fits) begin
                  for (int r = 0; r < NUM_RES; r++) work[r] += held[p][r];
                  safe_order[count] = p;
                  count++;
                  done[p] = 1'b1;
                  progress = 1'b1;
               end
            end
         end
         if (!progress) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic predict_allocator(input req_word_type w);
      int unsigned  amt[NUM_RES];
      logic [2:0]   st;
      int           p;
      rsp_word_type o;
      st = ST_OK;
      p = w.process;
      amt[0] = w.amount_0; amt[1] = w.amount_1;
      amt[2] = w.amount_2; amt[3] = w.amount_3;
      case (w.req_type)
         OP_LOAD_ALLOC: begin
            for (int r = 0; r < NUM_RES; r++) begin
               held[p][r] = amt[r];
               need[p][r] = 0;
            end
         end
         OP_LOAD_MAX: begin
            for (int r = 0; r < NUM_RES; r++)
               if (amt[r] < held[p][r]) st = ST_BADLOAD;
            if (st == ST_OK)
               for (int r = 0; r < NUM_RES; r++) need[p][r] = amt[r] - held[p][r];
         end
         OP_LOAD_AVAIL: begin
            for (int r = 0; r < NUM_RES; r++) pool[r] = amt[r];
         end
         OP_REQUEST: begin
            for (int r = 0; r < NUM_RES; r++)
               if (amt[r] > need[p][r]) st = ST_CLAIM;
            if (st == ST_OK)
               for (int r = 0; r < NUM_RES; r++)
                  if (amt[r] > pool[r]) st = ST_NOTAVAIL;
            if (st == ST_OK) begin
               for (int r = 0; r < NUM_RES; r++) begin
                  pool[r] -= amt[r]; held[p][r] += amt[r]; need[p][r] -= amt[r];
               end
               if (!state_is_safe()) begin
                  for (int r = 0; r < NUM_RES; r++) begin
                     pool[r] += amt[r]; held[p][r] -= amt[r]; need[p][r] += amt[r];
                  end
                  st = ST_UNSAFE;
               end
            end
         end
         OP_RELEASE: begin
            for (int r = 0; r < NUM_RES; r++)
               if (held[p][r] < amt[r]) st = ST_OVERREL;
            if (st == ST_OK)
               for (int r = 0; r < NUM_RES; r++) begin
                  pool[r] = (pool[r] + amt[r] > 255) ? 255 : pool[r] + amt[r];
                  held[p][r] -= amt[r];
                  need[p][r] = (need[p][r] + amt[r]) & 8'hff;
               end
         end
         OP_QUERY: begin
            if (state_is_safe()) begin
               for (int k = 0; k < NUM_PROC; k++) begin
                  o.status = ST_OK;
                  o.seq_process = 3'(safe_order[k]);
                  o.last = (k == NUM_PROC - 1);
                  pending_rsp.push_back(o);
               end
               return;
            end
            st = ST_UNSAFE;
         end
         default: ;
      endcase
      o.status = st; o.seq_process = '0; o.last = 1'b1;
      pending_rsp.push_back(o);
   endtask

   // sends one word, optional random gap before it
   task automatic send_word(input logic [2:0] op, input logic [2:0] p,
                            input logic [7:0] a0, input logic [7:0] a1,
                            input logic [7:0] a2, input logic [7:0] a3);
      req_word_type w;
      w = '{op, p, a0, a1, a2, a3};
      if (allow_gaps && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 6)) @(posedge clock);
      req_word <= w;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_allocator(w);
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected word: expected none, actual %p", $time, rsp_word);
            errors++;
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_word.status !== e.status || rsp_word.seq_process !== e.seq_process ||
                rsp_word.last !== e.last) begin
               $display("%0t mismatch: expected %p, actual %p", $time, e, rsp_word);
               errors++;
            end
         end
      end
   end

   task automatic test_directed();
      send_word(OP_QUERY, 0, 0, 0, 0, 0);             // empty state is safe
      send_word(OP_LOAD_AVAIL, 0, 8'hff, 8'hff, 8'hff, 8'hff);
      send_word(OP_LOAD_ALLOC, 7, 8'hff, 0, 8'hff, 0);
      send_word(OP_LOAD_MAX, 7, 8'hfe, 0, 8'hff, 0);    // below held
      send_word(OP_LOAD_MAX, 7, 8'hff, 8'hff, 8'hff, 8'hff);
      send_word(OP_RELEASE, 7, 8'hff, 1, 0, 0);         // over release
      send_word(OP_RELEASE, 7, 8'hff, 0, 8'hff, 0);     // saturating pool
      send_word(OP_REQUEST, 7, 0, 0, 0, 8'hff);
      send_word(OP_REQUEST, 0, 1, 0, 0, 0);             // exceeds claim
      send_word(OP_LOAD_AVAIL, 0, 2, 2, 2, 2);
      send_word(OP_LOAD_ALLOC, 0, 1, 1, 1, 1);
      send_word(OP_LOAD_MAX, 0, 9, 9, 9, 9);
      send_word(OP_LOAD_ALLOC, 1, 0, 0, 0, 0);
      send_word(OP_LOAD_MAX, 1, 9, 9, 9, 9);
      send_word(OP_REQUEST, 0, 3, 0, 0, 0);             // not available
      send_word(OP_REQUEST, 0, 2, 2, 2, 2);             // unsafe, rolled back
      send_word(OP_QUERY, 3, 0, 0, 0, 0);
      send_word(OP_REQUEST, 1, 1, 0, 0, 0);
      send_word(OP_QUERY, 0, 0, 0, 0, 0);
      send_word(OP_SPARE_6, 2, 8'h55, 8'haa, 0, 0);     // unused code
      send_word(OP_SPARE_7, 5, 8'haa, 8'h55, 0, 0);
      wait_drained();
   endtask

   task automatic test_random(input int n);
      logic [2:0] op;
      logic [2:0] p;
      for (int i = 0; i < n; i++) begin
         p = 3'($urandom_range(0, 7));
         case ($urandom_range(0, 9))
            0: op = OP_LOAD_ALLOC;
            1: op = OP_LOAD_MAX;
            2: op = OP_LOAD_AVAIL;
            3, 4, 5: op = OP_REQUEST;
            6, 7: op = OP_RELEASE;
            8: op = OP_QUERY;
            default: op = 3'($urandom_range(0, 7));
         endcase
         if ($urandom_range(0, 7) == 0)
            send_word(op, p, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         else
            send_word(op, p, 8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)),
                      8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)));
         if (i == n / 2) wait_drained();   // hold until all words are back
      end
      wait_drained();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(200);
      allow_gaps = 1'b0;
      test_random(50);
      if (errors == 0)
         $display("bankers_resource_allocator test passed");
      else
         $display("bankers_resource_allocator test failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("bankers_resource_allocator test failed");
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+src
src/bra_pkg.sv
src/bra_datapath.sv
src/bra_ctrl.sv
src/bankers_resource_allocator.sv
verif/bankers_resource_allocator_test.sv
